// ===== rtl/ile_pkg.sv =====
// ----------------------------------------------------------------------------
// ile_pkg: shared definitions for the indexed list engine
// Command and status codes, fixed port widths and the per-cell control bundle.
// ----------------------------------------------------------------------------
package ile_pkg;

  // Fixed widths of the channel fields.
  localparam int OPCODE_W    = 3;
  localparam int POSITION_W  = 9;
  localparam int ELEM_PORT_W = 32;
  localparam int STATUS_W    = 3;
  localparam int FOUND_W     = 8;
  localparam int COUNT_W     = 9;

  // Command opcodes.
  localparam logic [OPCODE_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_GET    = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_SET    = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_FIND   = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_POP    = 3'd7;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STS_BAD_INDEX = 3'd1;
  localparam logic [STATUS_W-1:0] STS_NULL      = 3'd2;
  localparam logic [STATUS_W-1:0] STS_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd4;

  // Cell update operations.
  localparam logic [1:0] CELL_HOLD       = 2'd0;
  localparam logic [1:0] CELL_WRITE      = 2'd1;
  localparam logic [1:0] CELL_SHIFT_UP   = 2'd2;
  localparam logic [1:0] CELL_SHIFT_DOWN = 2'd3;

  typedef struct packed {
    logic [1:0] op;    // update applied at the next edge
    logic       find;  // hit means value match instead of position match
  } cell_ctl_t;

endpackage

// ===== rtl/ile_cell.sv =====
// ----------------------------------------------------------------------------
// ile_cell: one list slot
// Holds one element, takes its neighbor's value on a shift and reports a hit
// for position reads or value searches.
// ----------------------------------------------------------------------------
module ile_cell
  import ile_pkg::*;
#(
  parameter int EW    = 32,
  parameter int CMP_W = 9,
  parameter int INDEX = 0
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [CMP_W-1:0] pos,
  input  logic [CMP_W-1:0] cnt,
  input  logic [EW-1:0]    data,
  input  logic [EW-1:0]    left_i,
  input  logic [EW-1:0]    right_i,
  output logic [EW-1:0]    value_o,
  output logic             hit_o
);

  localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

  logic [EW-1:0] val_r;
  logic [EW-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    unique case (ctl.op)
      CELL_WRITE: begin
        if (IDX == pos) val_nxt = data;
      end
      CELL_SHIFT_UP: begin
        if (IDX > pos) val_nxt = left_i;
        else if (IDX == pos) val_nxt = data;
      end
      CELL_SHIFT_DOWN: begin
        if (IDX >= pos) val_nxt = right_i;
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  // Slots at or above the count hold stale data and must never match a search.
  assign hit_o   = ctl.find ? ((val_r == data) && (IDX < cnt)) : (IDX == pos);
  assign value_o = val_r;

endmodule

// ===== rtl/ile_tree.sv =====
// ----------------------------------------------------------------------------
// ile_tree: registered priority tree over the cell hits
// Returns the lowest-index hit with its index and value; a register every four
// levels and at the root.
// ----------------------------------------------------------------------------
module ile_tree #(
  parameter int CAP = 256,
  parameter int EW  = 32
) (
  input  logic                    clk,
  input  logic                    leaf_hit [CAP],
  input  logic [EW-1:0]           leaf_val [CAP],
  output logic                    root_hit,
  output logic [$clog2(CAP)-1:0]  root_idx,
  output logic [EW-1:0]           root_val
);

  localparam int LEVELS = $clog2(CAP);
  localparam int P      = 1 << LEVELS;
  localparam int NODES  = 2 * P;

  // Heap layout: node k has children 2k and 2k+1; leaves sit at P..2P-1.
  logic              hit_n [NODES];
  logic [LEVELS-1:0] idx_n [NODES];
  logic [EW-1:0]     val_n [NODES];

  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < CAP) begin : g_used
      assign hit_n[P+i] = leaf_hit[i];
      assign idx_n[P+i] = LEVELS'(i);
      assign val_n[P+i] = leaf_val[i];
    end else begin : g_pad
      assign hit_n[P+i] = 1'b0;
      assign idx_n[P+i] = LEVELS'(i);
      assign val_n[P+i] = '0;
    end
  end

  for (genvar k = 1; k < P; k++) begin : g_node
    localparam int DEPTH = $clog2(k + 1) - 1;
    localparam int LVL   = LEVELS - 1 - DEPTH;
    localparam bit REG   = ((LVL % 4) == 3) || (LVL == LEVELS - 1);

    logic              sel_hit;
    logic [LEVELS-1:0] sel_idx;
    logic [EW-1:0]     sel_val;

    always_comb begin
      sel_hit = hit_n[2*k] | hit_n[2*k+1];
      if (hit_n[2*k]) begin
        sel_idx = idx_n[2*k];
        sel_val = val_n[2*k];
      end else begin
        sel_idx = idx_n[2*k+1];
        sel_val = val_n[2*k+1];
      end
    end

    if (REG) begin : g_reg
      logic              hit_r;
      logic [LEVELS-1:0] idx_r;
      logic [EW-1:0]     val_r;

      always_ff @(posedge clk) begin
        hit_r <= sel_hit;
        idx_r <= sel_idx;
        val_r <= sel_val;
      end

      assign hit_n[k] = hit_r;
      assign idx_n[k] = idx_r;
      assign val_n[k] = val_r;
    end else begin : g_comb
      assign hit_n[k] = sel_hit;
      assign idx_n[k] = sel_idx;
      assign val_n[k] = sel_val;
    end
  end

  assign root_hit = hit_n[1];
  assign root_idx = idx_n[1];
  assign root_val = val_n[1];

endmodule

// ===== rtl/indexed_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// indexed_list_engine_top: fixed-capacity ordered list of element words
// A row of cells holds the entries and shifts them for insert, remove and
// pop; a registered priority tree serves get, pop and find.
//
//   channel | ports                                         | direction
//   --------+-----------------------------------------------+----------
//   in      | in_valid, in_stall, in_opcode/position/element | command in
//   out     | out_valid, out_stall, out_status, out_element_out,
//           | out_found_index, out_count, out_empty_res      | result out
//
// Each command waits for the register stages of the priority tree, and
// the engine takes one command at a time.
// Reset clears the entry count and control state only; the cells need no clearing pass.
// A stalled result holds the engine in its write-back state; the list
// changes only when the result is loaded into the output register.
// ----------------------------------------------------------------------------
module indexed_list_engine_top
  import ile_pkg::*;
#(
  parameter int CAPACITY      = 256,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [OPCODE_W-1:0]    in_opcode,
  input  logic [POSITION_W-1:0]  in_position,
  input  logic [ELEM_PORT_W-1:0] in_element,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [STATUS_W-1:0]    out_status,
  output logic [ELEM_PORT_W-1:0] out_element_out,
  output logic [FOUND_W-1:0]     out_found_index,
  output logic [COUNT_W-1:0]     out_count,
  output logic                   out_empty_res
);

  localparam int EW       = ELEMENT_WIDTH;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;
  localparam int TREE_LAT = (IDX_W + 3) / 4;
  localparam int WAIT_W   = $clog2(TREE_LAT + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [WAIT_W-1:0]     wait_r, wait_nxt;
  logic [CNT_W-1:0]      count_r, cnt_nxt;
  logic [OPCODE_W-1:0]   op_r;
  logic [POSITION_W-1:0] pos_r;
  logic [EW-1:0]         elem_r;

  logic                  accept;
  logic                  out_free;
  logic                  commit;

  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      cnt_ext;
  logic [CMP_W-1:0]      cell_pos;
  logic                  elem_zero;
  logic                  full;
  logic                  bad_idx;
  logic                  bad_ins;

  logic [STATUS_W-1:0]   res_status;
  logic [EW-1:0]         res_elem;
  logic [IDX_W-1:0]      res_found;
  logic [1:0]            upd_op;
  cell_ctl_t             ctl;

  logic                  cell_hit [CAPACITY];
  logic [EW-1:0]         cell_val [CAPACITY];
  logic                  root_hit;
  logic [IDX_W-1:0]      root_idx;
  logic [EW-1:0]         root_val;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign commit   = (state_r == S_WRITE) && out_free;

  // ---------------- control ----------------
  always_comb begin
    state_nxt = state_r;
    wait_nxt  = wait_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RUN;
          wait_nxt  = WAIT_W'(TREE_LAT - 1);
        end
      end
      S_RUN: begin
        if (wait_r == '0) state_nxt = S_WRITE;
        else wait_nxt = wait_r - WAIT_W'(1);
      end
      S_WRITE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wait_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      wait_r  <= wait_nxt;
      if (commit) count_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_opcode;
      pos_r  <= in_position;
      elem_r <= EW'(in_element);
    end
  end

  // ---------------- command decode ----------------
  assign pos_ext   = CMP_W'(pos_r);
  assign cnt_ext   = CMP_W'(count_r);
  assign elem_zero = (elem_r == '0);
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign bad_idx   = (pos_ext >= cnt_ext);
  assign bad_ins   = (pos_ext > cnt_ext);
  assign cell_pos  = (op_r == OP_APPEND) ? cnt_ext : pos_ext;

  always_comb begin
    res_status = STS_OK;
    res_elem   = '0;
    res_found  = '0;
    cnt_nxt    = count_r;
    upd_op     = CELL_HOLD;
    unique case (op_r)
      OP_APPEND: begin
        if (elem_zero) res_status = STS_NULL;
        else if (full) res_status = STS_FULL;
        else begin
          upd_op  = CELL_WRITE;
          cnt_nxt = count_r + CNT_W'(1);
        end
      end
      OP_INSERT: begin
        if (elem_zero) res_status = STS_NULL;
        else if (bad_ins) res_status = STS_BAD_INDEX;
        else if (full) res_status = STS_FULL;
        else begin
          upd_op  = CELL_SHIFT_UP;
          cnt_nxt = count_r + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (bad_idx) res_status = STS_BAD_INDEX;
        else begin
          upd_op  = CELL_SHIFT_DOWN;
          cnt_nxt = count_r - CNT_W'(1);
        end
      end
      OP_GET: begin
        if (bad_idx) res_status = STS_BAD_INDEX;
        else res_elem = root_val;
      end
      OP_SET: begin
        if (elem_zero) res_status = STS_NULL;
        else if (bad_idx) res_status = STS_BAD_INDEX;
        else upd_op = CELL_WRITE;
      end
      OP_FIND: begin
        if (elem_zero) res_status = STS_NULL;
        else if (root_hit) res_found = root_idx;
        else res_status = STS_NOT_FOUND;
      end
      OP_CLEAR: begin
        cnt_nxt = '0;
      end
      OP_POP: begin
        if (bad_idx) res_status = STS_BAD_INDEX;
        else begin
          res_elem = root_val;
          upd_op   = CELL_SHIFT_DOWN;
          cnt_nxt  = count_r - CNT_W'(1);
        end
      end
      default: res_status = STS_OK;
    endcase
  end

  assign ctl.op   = commit ? upd_op : CELL_HOLD;
  assign ctl.find = (op_r == OP_FIND);

  // ---------------- cell row ----------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [EW-1:0] left_v;
    logic [EW-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = cell_val[i];
    end else begin : g_left
      assign left_v = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_v = cell_val[i];
    end else begin : g_right
      assign right_v = cell_val[i+1];
    end

    ile_cell #(
      .EW    (EW),
      .CMP_W (CMP_W),
      .INDEX (i)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .pos     (cell_pos),
      .cnt     (cnt_ext),
      .data    (elem_r),
      .left_i  (left_v),
      .right_i (right_v),
      .value_o (cell_val[i]),
      .hit_o   (cell_hit[i])
    );
  end

  ile_tree #(
    .CAP (CAPACITY),
    .EW  (EW)
  ) u_tree (
    .clk      (clk),
    .leaf_hit (cell_hit),
    .leaf_val (cell_val),
    .root_hit (root_hit),
    .root_idx (root_idx),
    .root_val (root_val)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status      <= res_status;
      out_element_out <= ELEM_PORT_W'(res_elem);
      out_found_index <= FOUND_W'(res_found);
      out_count       <= COUNT_W'(cnt_nxt);
      out_empty_res   <= (cnt_nxt == '0);
    end
  end

endmodule
